@@ sv/tcw_pkg.sv @@
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths (fixed by the port definition)
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 11;

    // Internal widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CUR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int DATA_W = CHAR_W + ATTR_W;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUT       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BACKSPACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
    localparam logic [ATTR_W-1:0] BLANK_ATTR     = 8'd15;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic accept;       // latch request, issue cell read
        logic exec;         // apply request to screen and cursor
        logic scroll_step;  // one row-move copy step
        logic fill_step;    // one fill write
        logic fill_mark;    // fill is the blank bottom row
        logic push;         // load result register
    } tcw_cmd_t;

    typedef struct packed {
        logic overflow;     // cursor ran past the last cell
        logic copy_end;     // row move finished
        logic fill_last;    // fill at last cell
        logic slot_free;    // result register can take a result
    } tcw_status_t;

endpackage

@@ sv/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/tcw_datapath.sv @@
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_cmd_t          cmd,
    output tcw_status_t       status,
    input  logic [KIND_W-1:0] kind,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CELL_W-1:0] cell_index,
    input  logic              cfg_valid,
    input  logic [ATTR_W-1:0] text_attribute,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CELL_W-1:0] cursor_position,
    output logic [CHAR_W-1:0] read_char,
    output logic [ATTR_W-1:0] read_attr,
    output logic              scrolled
);

    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] code_reg;
    logic              in_range_reg;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              scrolled_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_cursor_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [ATTR_W-1:0] out_attr_reg;
    logic              out_scrolled_reg;

    logic [CUR_W-1:0]  cursor_adv, cursor_exec;
    logic [COL_W-1:0]  col_adv;
    logic              exec_wr;
    logic [ADDR_W-1:0] exec_wr_addr;
    logic [DATA_W-1:0] exec_wr_data;
    logic              overflow;
    logic              copy_end, fill_last;

    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

    // Request action: cursor advance and the single cell write
    always_comb
    begin
        cursor_adv   = cursor_reg;
        col_adv      = col_reg;
        exec_wr      = 1'b0;
        exec_wr_addr = ADDR_W'(cursor_reg);
        exec_wr_data = {attr_reg, code_reg};
        case (kind_reg)
            KIND_PUT:
            begin
                if (code_reg == NEWLINE_CODE)
                begin
                    cursor_adv = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
                    col_adv    = '0;
                end
                else
                begin
                    exec_wr    = 1'b1;
                    cursor_adv = cursor_reg + CUR_W'(1);
                    col_adv    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
                end
            end
            KIND_BACKSPACE:
            begin
                if (cursor_reg != '0)
                begin
                    exec_wr      = 1'b1;
                    cursor_adv   = cursor_reg - CUR_W'(1);
                    col_adv      = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
                    exec_wr_addr = ADDR_W'(cursor_reg - CUR_W'(1));
                    exec_wr_data = {BLANK_ATTR, CHAR_W'(0)};
                end
            end
            default:
            begin
            end
        endcase
        overflow    = (kind_reg == KIND_PUT) && (cursor_adv >= CUR_W'(CELL_COUNT));
        cursor_exec = overflow ? cursor_adv - CUR_W'(COLUMNS) : cursor_adv;
    end

    assign copy_end  = (cnt_reg == ADDR_W'(CELL_COUNT - COLUMNS));
    assign fill_last = (cnt_reg == ADDR_W'(CELL_COUNT - 1));

    // Memory port steering
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = exec_wr_addr;
        ram_wr_data = exec_wr_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(cell_index);
        if (cmd.accept)
        begin
            ram_rd_en = 1'b1;
        end
        if (cmd.exec)
        begin
            ram_wr_en = exec_wr;
        end
        if (cmd.scroll_step)
        begin
            // the RAM registers the read, which feeds the write of the next step
            ram_rd_en   = !copy_end;
            ram_rd_addr = cnt_reg + ADDR_W'(COLUMNS);
            ram_wr_en   = (cnt_reg != '0);
            ram_wr_addr = cnt_reg - ADDR_W'(1);
            ram_wr_data = ram_rd_data;
        end
        if (cmd.fill_step)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_reg;
            ram_wr_data = (cmd.fill_mark && copy_end) ? {BLANK_ATTR, CHAR_W'(0)} : '0;
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        if (cmd.exec)
        begin
            cursor_next = cursor_exec;
            col_next    = col_adv;
            cnt_next    = '0;
        end
        if (cmd.scroll_step && !copy_end)
        begin
            cnt_next = cnt_reg + ADDR_W'(1);
        end
        if (cmd.fill_step)
        begin
            cnt_next = cnt_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg     <= kind;
            code_reg     <= char_code;
            in_range_reg <= (cell_index < CELL_W'(CELL_COUNT));
        end
        if (cmd.exec)
        begin
            scrolled_reg <= overflow;
        end
        if (cmd.push)
        begin
            out_cursor_reg   <= CELL_W'(cmd.exec ? cursor_exec : cursor_reg);
            out_scrolled_reg <= cmd.exec ? overflow : scrolled_reg;
            if ((kind_reg == KIND_READ) && in_range_reg)
            begin
                out_char_reg <= ram_rd_data[CHAR_W-1:0];
                out_attr_reg <= ram_rd_data[DATA_W-1:CHAR_W];
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign status.overflow  = overflow;
    assign status.copy_end  = copy_end;
    assign status.fill_last = fill_last;
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign cursor_position = out_cursor_reg;
    assign read_char       = out_char_reg;
    assign read_attr       = out_attr_reg;
    assign scrolled        = out_scrolled_reg;

endmodule

@@ sv/tcw_ctrl.sv @@
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tcw_status_t status,
    output tcw_cmd_t    cmd
);

    tcw_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.overflow)
                begin
                    state_next = ST_SCROLL;
                end
                else if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCROLL:
            begin
                if (status.copy_end)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.push = !status.overflow && status.slot_free;
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
            end
            ST_BLANK:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_mark = 1'b1;
            end
            ST_RESP:
            begin
                cmd.push = status.slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/text_console_writer_core.sv @@
// Text console writer: takes one put, backspace or read request at a time and takes no new
// request until the last one has executed and its result is loaded into the result register.
// A put that runs past the last cell scrolls: a row move that copies through the single
// screen RAM, a pass that blanks the bottom row, and the hand-off of the result. After reset
// a clearing pass writes zero to all CELL_COUNT cells while in_ready stays low; attribute
// writes are taken at any time.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CELL_W-1:0] cell_index,

    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CELL_W-1:0] cursor_position,
    output logic [CHAR_W-1:0] read_char,
    output logic [ATTR_W-1:0] read_attr,
    output logic              scrolled,

    // attribute register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] text_attribute
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    // The attribute register is a plain flop; it never stalls a write.
    assign cfg_ready = 1'b1;

    // Sequencer: reset clear, request execute, row move, bottom-row blank, result hand-off.
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Screen RAM, cursor/column tracking and the result register. The result register
    // lets a finished result wait for the consumer while the sequencer returns to idle.
    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .kind            (kind),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cfg_valid       (cfg_valid),
        .text_attribute  (text_attribute),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_position (cursor_position),
        .read_char       (read_char),
        .read_attr       (read_attr),
        .scrolled        (scrolled)
    );

endmodule

@@ tb/sv/tb_text_console_writer_core.sv @@
import tcw_pkg::*;

// One result of the console as the testbench predicts it.
typedef struct packed {
    logic [CELL_W-1:0] cursor;
    logic [CHAR_W-1:0] rchar;
    logic [ATTR_W-1:0] rattr;
    logic              scrolled;
} console_report_t;

// Shadow screen, cursor and attribute, plus the reports still owed by the block.
class screen_scoreboard;
    logic [DATA_W-1:0] cells [CELL_COUNT];
    int                cursor;
    logic [ATTR_W-1:0] attribute;
    console_report_t   due_reports [$];
    int                errors;

    function new();
        foreach (cells[i])
            cells[i] = '0;
        cursor    = 0;
        attribute = ATTR_RESET;
        errors    = 0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
        attribute = value;
    endfunction

    // Bottom row comes back blank except for the attribute of its first cell.
    function void scroll_screen();
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            cells[i] = cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            cells[i] = '0;
        cells[CELL_COUNT - COLUMNS] = {BLANK_ATTR, {CHAR_W{1'b0}}};
    endfunction

    // Accepted request: update the shadow state and queue the report it causes.
    function void apply_request(logic [KIND_W-1:0] req_kind, logic [CHAR_W-1:0] code,
                                logic [CELL_W-1:0] index);
        console_report_t rep;
        rep = '0;
        if (req_kind == KIND_PUT) begin
            if (code == NEWLINE_CODE)
                cursor = (cursor / COLUMNS + 1) * COLUMNS;
            else begin
                cells[cursor] = {attribute, code};
                cursor++;
            end
            if (cursor >= CELL_COUNT) begin
                scroll_screen();
                cursor -= COLUMNS;
                rep.scrolled = 1'b1;
            end
        end
        else if (req_kind == KIND_BACKSPACE) begin
            if (cursor > 0) begin
                cursor--;
                cells[cursor] = {BLANK_ATTR, {CHAR_W{1'b0}}};
            end
        end
        else if (req_kind == KIND_READ) begin
            if (index < CELL_COUNT) begin
                rep.rchar = cells[index][CHAR_W-1:0];
                rep.rattr = cells[index][DATA_W-1:CHAR_W];
            end
        end
        rep.cursor = cursor[CELL_W-1:0];
        due_reports.push_back(rep);
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Accepted result: compare against the oldest queued report.
    function void match_report(console_report_t got);
        console_report_t want;
        if (due_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual cursor %0d", $time,
                     got.cursor);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        check_field("cursor_position", int'(want.cursor), int'(got.cursor));
        check_field("read_char", int'(want.rchar), int'(got.rchar));
        check_field("read_attr", int'(want.rattr), int'(got.rattr));
        check_field("scrolled", int'(want.scrolled), int'(got.scrolled));
    endfunction
endclass

module tb_text_console_writer_core;

    // Unused request kind; the block must treat it as a no-op.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Longest silent stretch is a scroll or the clearing pass.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 250;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [KIND_W-1:0] kind = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [CELL_W-1:0] cell_index = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CELL_W-1:0] cursor_position;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic              scrolled;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] text_attribute = '0;

    screen_scoreboard sb = new();
    int               idle_cycles = 0;

    text_console_writer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_position (cursor_position),
        .read_char       (read_char),
        .read_attr       (read_attr),
        .scrolled        (scrolled),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .text_attribute  (text_attribute)
    );

    always #5 clk = ~clk;

    // Watchdog: any accepted request, result or attribute write resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one request. Valid is only dropped when a gap is drawn, so back-to-back
    // requests keep it high across the accepting edge.
    task automatic offer_request(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] code,
                                 logic [CELL_W-1:0] index, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        char_code  <= code;
        cell_index <= index;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.apply_request(k, code, index);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_valid      <= 1'b1;
        text_attribute <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_attribute(value);
        cfg_valid <= 1'b0;
    endtask

    // Block is idle once every queued report has come back (each request yields one).
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.due_reports.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, bursts with none, and one long hold-off that
    // backs the block up while the sender keeps offering.
    initial
    begin
        int              stall;
        int              taken;
        console_report_t got;
        taken = 0;
        forever
        begin
            if (taken == 300)
            begin
                out_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge clk);
            end
            stall = (((taken / 50) % 4) == 1) ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got.cursor   = cursor_position;
            got.rchar    = read_char;
            got.rattr    = read_attr;
            got.scrolled = scrolled;
            sb.match_report(got);
            taken++;
        end
    end

    // Request side and phase sequencing.
    initial
    begin
        int                pick;
        int                lo;
        logic [KIND_W-1:0] k;
        logic [CHAR_W-1:0] code;
        logic [CELL_W-1:0] index;
        logic [ATTR_W-1:0] attr;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // low extreme of the attribute; taken even during the clearing pass
        write_attribute(8'h00);

        // Directed: backspace at cell 0, extreme codes, newline, backspace
        // across a row boundary, reads at the screen edges and beyond it.
        offer_request(KIND_BACKSPACE, 8'hFF, 11'h7FF, 1'b0);
        offer_request(KIND_READ, 8'h00, 11'd0, 1'b0);
        offer_request(KIND_PUT, 8'h00, 11'd0, 1'b0);
        offer_request(KIND_PUT, 8'hFF, 11'h7FF, 1'b1);
        offer_request(KIND_PUT, NEWLINE_CODE, 11'd5, 1'b0);
        offer_request(KIND_BACKSPACE, 8'h00, 11'd0, 1'b1);
        offer_request(KIND_PUT, 8'h41, 11'd0, 1'b0);
        offer_request(KIND_READ, 8'hFF, 11'd0, 1'b1);
        offer_request(KIND_READ, 8'h00, 11'd1, 1'b1);
        offer_request(KIND_READ, 8'h00, 11'd79, 1'b0);
        offer_request(KIND_READ, 8'h00, 11'd80, 1'b0);
        offer_request(KIND_READ, 8'h00, CELL_W'(CELL_COUNT - 1), 1'b0);
        offer_request(KIND_READ, 8'h00, CELL_W'(CELL_COUNT), 1'b1);
        offer_request(KIND_READ, 8'hAA, 11'h7FF, 1'b0);
        offer_request(KIND_UNUSED, 8'hFF, 11'h7FF, 1'b0);
        offer_request(KIND_BACKSPACE, 8'h55, 11'h2AA, 1'b1);
        offer_request(KIND_BACKSPACE, 8'h00, 11'd0, 1'b0);
        offer_request(KIND_PUT, NEWLINE_CODE, 11'd0, 1'b0);
        offer_request(KIND_READ, 8'h00, 11'd78, 1'b0);
        offer_request(KIND_READ, 8'h00, 11'd79, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       attr = 8'hFF;
                3:       attr = BLANK_ATTR;
                default: attr = ATTR_W'($urandom_range(0, 255));
            endcase
            write_attribute(attr);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick  = $urandom_range(0, 99);
                code  = CHAR_W'($urandom_range(0, 255));
                index = CELL_W'($urandom_range(0, 2047));
                if (pick < 50)
                    k = KIND_PUT;
                else if (pick < 58)
                begin
                    k    = KIND_PUT;
                    code = NEWLINE_CODE;
                end
                else if (pick < 70)
                    k = KIND_BACKSPACE;
                else if (pick < 97)
                begin
                    k = KIND_READ;
                    // mostly look at what was just written, near the cursor
                    if (pick < 85)
                    begin
                        lo    = (sb.cursor > 160) ? sb.cursor - 160 : 0;
                        index = CELL_W'($urandom_range(lo, sb.cursor));
                    end
                    else if (pick < 91)
                        index = CELL_W'($urandom_range(0, CELL_COUNT - 1));
                end
                else
                    k = KIND_UNUSED;
                offer_request(k, code, index, ((i / 64) % 4) == 3);
            end
        end

        wait_drained();
        // keep running to catch a stray result
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_datapath.sv
sv/tcw_ctrl.sv
sv/text_console_writer_core.sv
tb/sv/tb_text_console_writer_core.sv
